[rtl/core/smis_pkg.sv]
// Package for the sorted matrix insert and search unit.
// Holds table geometry, action and status codes, and the result record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package smis_pkg;

    // Table geometry: SIDE x SIDE entries stored row by row.
    localparam int SIDE    = 32;
    localparam int ROW_W   = $clog2(SIDE);
    localparam int IDX_W   = 2 * ROW_W;
    localparam int DEPTH   = SIDE * SIDE;
    localparam int CNT_W   = IDX_W + 1;
    localparam int VAL_W   = 16;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_FOUND    = 3'd1,
        ST_MISSING  = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOT_FULL = 3'd4,
        ST_CLEARED  = 3'd5
    } status_t;

    typedef struct packed {
        status_t           status;
        logic [ROW_W-1:0]  row;
        logic [ROW_W-1:0]  col;
        logic [CNT_W-1:0]  fill;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/sorted_matrix_insert_and_search_unit.sv]
// Top level of the sorted matrix insert and search unit.
// Wraps the sequencer/memory engine and adds the output register.
// Depends on smis_pkg and smis_engine.
`timescale 1ns / 1ps
`default_nettype none

// Sorted 32 x 32 table of 16-bit values with insert, lookup and clear.
// Each input transaction yields exactly one output transaction. An insert
// places the value in ascending order after any equal values, shifting
// larger entries up one place; the shift moves one entry per cycle through
// the single read and single write port of the table memory. A lookup
// requires a full table; it runs a binary search over row heads and then
// within the chosen row, each probe being a memory read then a compare.
// Clear and refused transactions go straight to their result. The unit
// works on one transaction at a time: in_stall is high from acceptance
// until the result is handed to the output register. The output register
// lets a finished result wait on out_stall while the next input transaction
// is taken. The table needs no clearing pass after reset; entries beyond the
// fill count are never read.
module sorted_matrix_insert_and_search_unit (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [smis_pkg::ACT_W-1:0]   action,
    input  wire logic [smis_pkg::VAL_W-1:0]   item_value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [smis_pkg::STAT_W-1:0]       status,
    output logic [smis_pkg::ROW_W-1:0]        hit_row,
    output logic [smis_pkg::ROW_W-1:0]        hit_column,
    output logic [smis_pkg::CNT_W-1:0]        fill_count
);
    import smis_pkg::*;

    logic     eng_busy;
    logic     eng_res_valid;
    logic     eng_res_take;
    result_t  eng_res;

    logic     out_valid_reg, out_valid_next;
    result_t  out_res_reg, out_res_next;

    // The engine starts on an accepted input transaction.
    smis_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_valid && !eng_busy),
        .action     (action),
        .item_value (item_value),
        .busy       (eng_busy),
        .res_valid  (eng_res_valid),
        .res_take   (eng_res_take),
        .res        (eng_res)
    );

    assign in_stall = eng_busy;

    // Advance a finished result into the output register whenever the
    // register is empty or its transaction completes this cycle.
    assign eng_res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_res_next   = out_res_reg;
        if (eng_res_take)
        begin
            out_valid_next = eng_res_valid;
            if (eng_res_valid)
                out_res_next = eng_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            out_res_reg   <= out_res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = out_res_reg.status;
    assign hit_row    = out_res_reg.row;
    assign hit_column = out_res_reg.col;
    assign fill_count = out_res_reg.fill;

endmodule

`default_nettype wire

[rtl/core/smis_engine.sv]
// Sequencer and table memory of the sorted matrix insert and search unit.
// Runs insertion shifts, the two-level binary search and clear.
// Depends on smis_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smis_engine (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [smis_pkg::ACT_W-1:0]  action,
    input  wire logic [smis_pkg::VAL_W-1:0]  item_value,
    output logic                             busy,
    output logic                             res_valid,
    input  wire logic                        res_take,
    output smis_pkg::result_t                res
);
    import smis_pkg::*;

    localparam int CW = ROW_W + 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_ISSUE,
        S_INS_CMP,
        S_ROW_ISSUE,
        S_ROW_CMP,
        S_COL_ISSUE,
        S_COL_CMP,
        S_FINISH
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [VAL_W-1:0]        key_reg, key_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [ROW_W-1:0]        lo_row_reg, lo_row_next;
    logic [ROW_W-1:0]        hi_row_reg, hi_row_next;
    logic signed [CW-1:0]    lo_col_reg, lo_col_next;
    logic signed [CW-1:0]    hi_col_reg, hi_col_next;
    logic [ROW_W-1:0]        probe_reg, probe_next;
    result_t                 res_reg, res_next;

    logic [VAL_W-1:0]        mem [DEPTH];
    logic [VAL_W-1:0]        rd_data_reg;
    logic                    we;
    logic [IDX_W-1:0]        wa;
    logic [VAL_W-1:0]        wd;
    logic [IDX_W-1:0]        ra;

    logic [ROW_W:0]          row_sum;
    logic signed [CW:0]      col_sum;
    logic [ROW_W-1:0]        col_mid;

    assign row_sum = {1'b0, lo_row_reg} + {1'b0, hi_row_reg};
    assign col_sum = {lo_col_reg[CW-1], lo_col_reg} + {hi_col_reg[CW-1], hi_col_reg};
    assign col_mid = col_sum[ROW_W:1];

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        key_next    = key_reg;
        idx_next    = idx_reg;
        lo_row_next = lo_row_reg;
        hi_row_next = hi_row_reg;
        lo_col_next = lo_col_reg;
        hi_col_next = hi_col_reg;
        probe_next  = probe_reg;
        res_next    = res_reg;
        we          = 1'b0;
        wa          = idx_reg;
        wd          = key_reg;
        ra          = idx_reg - IDX_W'(1);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    key_next        = item_value;
                    idx_next        = count_reg[IDX_W-1:0];
                    lo_row_next     = '0;
                    hi_row_next     = ROW_W'(SIDE - 1);
                    res_next.row    = '0;
                    res_next.col    = '0;
                    res_next.fill   = count_reg;
                    if (action[1])
                    begin
                        // clear: drop all entries
                        count_next      = '0;
                        res_next.status = ST_CLEARED;
                        res_next.fill   = '0;
                        state_next      = S_FINISH;
                    end
                    else if (action == ACT_INSERT)
                    begin
                        if (count_reg == CNT_W'(DEPTH))
                        begin
                            res_next.status = ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_INS_ISSUE;
                        end
                    end
                    else
                    begin
                        if (count_reg != CNT_W'(DEPTH))
                        begin
                            res_next.status = ST_NOT_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_ROW_ISSUE;
                        end
                    end
                end
            end

            S_INS_ISSUE:
            begin
                if (idx_reg == '0)
                begin
                    we              = 1'b1;
                    wa              = '0;
                    wd              = key_reg;
                    count_next      = count_reg + CNT_W'(1);
                    res_next.status = ST_INSERTED;
                    res_next.fill   = count_reg + CNT_W'(1);
                    state_next      = S_FINISH;
                end
                else
                begin
                    ra         = idx_reg - IDX_W'(1);
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                // rd_data_reg holds entry idx-1
                we = 1'b1;
                wa = idx_reg;
                if (rd_data_reg > key_reg)
                begin
                    wd       = rd_data_reg;
                    idx_next = idx_reg - IDX_W'(1);
                    ra       = idx_reg - IDX_W'(2);
                    if (idx_reg == IDX_W'(1))
                        state_next = S_INS_ISSUE;
                end
                else
                begin
                    wd              = key_reg;
                    count_next      = count_reg + CNT_W'(1);
                    res_next.status = ST_INSERTED;
                    res_next.fill   = count_reg + CNT_W'(1);
                    state_next      = S_FINISH;
                end
            end

            S_ROW_ISSUE:
            begin
                if (lo_row_reg == hi_row_reg)
                begin
                    lo_col_next = '0;
                    hi_col_next = CW'(SIDE - 1);
                    state_next  = S_COL_ISSUE;
                end
                else
                begin
                    if (hi_row_reg - lo_row_reg == ROW_W'(1))
                        probe_next = hi_row_reg;
                    else
                        probe_next = row_sum[ROW_W:1];
                    ra         = {probe_next, {ROW_W{1'b0}}};
                    state_next = S_ROW_CMP;
                end
            end

            S_ROW_CMP:
            begin
                // both the adjacent and the general step reduce to this
                if (key_reg < rd_data_reg)
                    hi_row_next = probe_reg - ROW_W'(1);
                else
                    lo_row_next = probe_reg;
                state_next = S_ROW_ISSUE;
            end

            S_COL_ISSUE:
            begin
                if (lo_col_reg > hi_col_reg)
                begin
                    res_next.status = ST_MISSING;
                    state_next      = S_FINISH;
                end
                else
                begin
                    probe_next = col_mid;
                    ra         = {lo_row_reg, col_mid};
                    state_next = S_COL_CMP;
                end
            end

            S_COL_CMP:
            begin
                if (key_reg == rd_data_reg)
                begin
                    res_next.status = ST_FOUND;
                    res_next.row    = lo_row_reg;
                    res_next.col    = probe_reg;
                    state_next      = S_FINISH;
                end
                else
                begin
                    if (key_reg < rd_data_reg)
                        hi_col_next = {2'b00, probe_reg} - CW'(1);
                    else
                        lo_col_next = {2'b00, probe_reg} + CW'(1);
                    state_next = S_COL_ISSUE;
                end
            end

            S_FINISH:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            key_reg    <= '0;
            idx_reg    <= '0;
            lo_row_reg <= '0;
            hi_row_reg <= '0;
            lo_col_reg <= '0;
            hi_col_reg <= '0;
            probe_reg  <= '0;
            res_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            key_reg    <= key_next;
            idx_reg    <= idx_next;
            lo_row_reg <= lo_row_next;
            hi_row_reg <= hi_row_next;
            lo_col_reg <= lo_col_next;
            hi_col_reg <= hi_col_next;
            probe_reg  <= probe_next;
            res_reg    <= res_next;
        end
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        rd_data_reg <= mem[ra];
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_FINISH);
    assign res       = res_reg;

endmodule

`default_nettype wire

[tb/sv/sorted_table_checker.sv]
// Checker for the sorted matrix insert and search unit.
// Watches both channels, predicts each result and compares it field by field.
// Depends on smis_pkg.
`timescale 1ns / 1ps

module sorted_table_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire logic [smis_pkg::ACT_W-1:0]   action,
    input  wire logic [smis_pkg::VAL_W-1:0]   item_value,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [smis_pkg::STAT_W-1:0]  status,
    input  wire logic [smis_pkg::ROW_W-1:0]   hit_row,
    input  wire logic [smis_pkg::ROW_W-1:0]   hit_column,
    input  wire logic [smis_pkg::CNT_W-1:0]   fill_count,
    output int                                fail_count,
    output int                                outstanding
);
    import smis_pkg::*;

    logic [VAL_W-1:0] shadow_entries [DEPTH];
    int               shadow_count;
    result_t          pending_results [$];

    // Insertion sort step: walk down past larger entries, stop at entry 0.
    function automatic void shift_in(input logic [VAL_W-1:0] val);
        int slot;
        slot = shadow_count;
        while (slot > 0 && shadow_entries[slot-1] > val) begin
            shadow_entries[slot] = shadow_entries[slot-1];
            slot--;
        end
        shadow_entries[slot] = val;
        shadow_count++;
    endfunction

    // Binary search over row heads, then over the columns of the chosen row.
    function automatic bit locate_key(input logic [VAL_W-1:0] key,
                                      output int hit_r, output int hit_c);
        int lo_r;
        int hi_r;
        int lo_c;
        int hi_c;
        int mid;
        logic [VAL_W-1:0] probe;
        lo_r  = 0;
        hi_r  = SIDE - 1;
        lo_c  = 0;
        hi_c  = SIDE - 1;
        hit_r = 0;
        hit_c = 0;
        while (lo_r != hi_r) begin
            if (hi_r - lo_r == 1) begin
                if (key < shadow_entries[hi_r*SIDE])
                    hi_r--;
                else
                    lo_r++;
            end
            else begin
                mid = (lo_r + hi_r) / 2;
                if (key < shadow_entries[mid*SIDE])
                    hi_r = mid - 1;
                else
                    lo_r = mid;
            end
        end
        while (lo_c <= hi_c) begin
            mid   = (lo_c + hi_c) / 2;
            probe = shadow_entries[lo_r*SIDE + mid];
            if (key == probe) begin
                hit_r = lo_r;
                hit_c = mid;
                return 1'b1;
            end
            if (key < probe)
                hi_c = mid - 1;
            else
                lo_c = mid + 1;
        end
        return 1'b0;
    endfunction

    function automatic result_t apply_table_action(input logic [ACT_W-1:0] act,
                                                   input logic [VAL_W-1:0] val);
        result_t res;
        int r;
        int c;
        res = '0;
        r   = 0;
        c   = 0;
        // Only the upper action bit selects clear.
        if (act[1]) begin
            shadow_count = 0;
            res.status   = ST_CLEARED;
        end
        else if (act == ACT_INSERT) begin
            if (shadow_count >= DEPTH)
                res.status = ST_FULL;
            else begin
                shift_in(val);
                res.status = ST_INSERTED;
            end
        end
        else if (shadow_count != DEPTH)
            res.status = ST_NOT_FULL;
        else if (locate_key(val, r, c)) begin
            res.status = ST_FOUND;
            res.row    = ROW_W'(r);
            res.col    = ROW_W'(c);
        end
        else
            res.status = ST_MISSING;
        res.fill = CNT_W'(shadow_count);
        return res;
    endfunction

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", label, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        result_t want;
        if (!rst_n) begin
            pending_results.delete();
            shadow_count = 0;
            fail_count   = 0;
            outstanding <= 0;
        end
        else begin
            if (in_valid && !in_stall)
                pending_results.push_back(apply_table_action(action, item_value));
            if (out_valid && !out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with no transaction waiting: status %0d", status);
                    fail_count++;
                end
                else begin
                    want = pending_results.pop_front();
                    check_field("status", want.status, status);
                    check_field("hit_row", want.row, hit_row);
                    check_field("hit_column", want.col, hit_column);
                    check_field("fill_count", want.fill, fill_count);
                end
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

[tb/sv/sorted_matrix_insert_and_search_unit_tb.sv]
// Testbench top for the sorted matrix insert and search unit.
// Drives stimulus and output stalls, gives the verdict.
// Depends on smis_pkg, sorted_table_checker and the unit itself.
`timescale 1ns / 1ps

module sorted_matrix_insert_and_search_unit_tb;
    import smis_pkg::*;

    // Code 3 is unused, but the unit decodes only the upper bit for clear.
    localparam logic [ACT_W-1:0] ACT_CLEAR_ALT = 2'd3;
    localparam int SETTLE_CYCLES = 1100;   // longest insert plus margin

    logic              clk        = 1'b0;
    logic              rst_n      = 1'b0;
    logic              in_valid   = 1'b0;
    logic [ACT_W-1:0]  action     = ACT_INSERT;
    logic [VAL_W-1:0]  item_value = '0;
    logic              out_stall  = 1'b0;
    logic              in_stall;
    logic              out_valid;
    logic [STAT_W-1:0] status;
    logic [ROW_W-1:0]  hit_row;
    logic [ROW_W-1:0]  hit_column;
    logic [CNT_W-1:0]  fill_count;
    int                fail_count;
    int                outstanding;

    // Values inserted since the last clear; they pace the fill and aim lookups at hits.
    logic [VAL_W-1:0]  stored_values [$];
    bit                burst_mode = 1'b0;
    int                stall_run  = 0;

    always #5 clk = ~clk;

    sorted_matrix_insert_and_search_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .action     (action),
        .item_value (item_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .hit_row    (hit_row),
        .hit_column (hit_column),
        .fill_count (fill_count)
    );

    sorted_table_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .item_value  (item_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .hit_row     (hit_row),
        .hit_column  (hit_column),
        .fill_count  (fill_count),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Mostly back to back, often a few cycles, now and then a long pause.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Output stall pattern: short stalls, short open runs, and occasional
    // long calm stretches with no stall at all.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_run <= 0;
        end
        else if (stall_run > 0)
            stall_run <= stall_run - 1;
        else if (!out_stall && $urandom_range(0, 2) == 0) begin
            out_stall <= 1'b1;
            stall_run <= pick_gap();
        end
        else if ($urandom_range(0, 15) == 0) begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(100, 400);
        end
        else begin
            out_stall <= 1'b0;
            stall_run <= $urandom_range(0, 6);
        end
    end

    // Present one transaction and hold it until the unit takes it. Valid
    // stays high on return so the next transaction can follow without a gap.
    task automatic send(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val);
        int gap;
        gap = burst_mode ? 0 : pick_gap();
        repeat (gap) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        action     <= act;
        item_value <= val;
        do
            @(posedge clk);
        while (in_stall);
        // Track what the table should hold, for choosing lookup keys.
        if (act[1])
            stored_values.delete();
        else if (act == ACT_INSERT && stored_values.size() < DEPTH)
            stored_values.push_back(val);
    endtask

    // Drop valid and hold off until every result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Fill the table up to DEPTH entries. Kind 0 is a rising ramp from 0 to
    // 0xFFFF with scattered random values that force long shifts; kind 1 is
    // fully random; kind 2 is a slow ramp that packs many equal values.
    task automatic fill_table(input int kind);
        int ramp;
        int ramp_base;
        logic [VAL_W-1:0] val;
        ramp      = (kind == 2) ? $urandom_range(0, 64000) : 0;
        ramp_base = ramp;
        while (stored_values.size() < DEPTH) begin
            burst_mode = (stored_values.size() < 150);
            // Drop in an early lookup now and then: refused, table not full.
            if ($urandom_range(0, 99) < 3)
                send(ACT_LOOKUP, VAL_W'($urandom));
            if (kind == 0) begin
                if (stored_values.size() == 0)
                    val = '0;
                else if (stored_values.size() == DEPTH - 1)
                    val = '1;
                else if ($urandom_range(0, 99) < 10)
                    val = VAL_W'($urandom);
                else begin
                    ramp = ramp + $urandom_range(0, 70);
                    if (ramp > 65535)
                        ramp = 65535;
                    val = VAL_W'(ramp);
                end
            end
            else if (kind == 1)
                val = VAL_W'($urandom);
            else begin
                if ($urandom_range(0, 99) < 5) begin
                    ramp_base = ramp_base + $urandom_range(0, 600);
                    if (ramp_base > 65535)
                        ramp_base = 65535;
                    val = VAL_W'(ramp_base);
                    ramp_base = ramp;
                end
                else begin
                    ramp = ramp + $urandom_range(0, 1);
                    if (ramp > 65535)
                        ramp = 65535;
                    val = VAL_W'(ramp);
                end
            end
            send(ACT_INSERT, val);
        end
        burst_mode = 1'b0;
    endtask

    // Exercise a full table: refused inserts, extreme keys, then lookups
    // aimed mostly at stored values, with random misses and refused inserts mixed in.
    task automatic probe_full_table();
        int roll;
        send(ACT_INSERT, VAL_W'($urandom));
        send(ACT_INSERT, '0);
        send(ACT_LOOKUP, '0);
        send(ACT_LOOKUP, '1);
        send(ACT_LOOKUP, stored_values[0]);
        send(ACT_LOOKUP, stored_values[DEPTH-1]);
        repeat (110) begin
            roll = $urandom_range(0, 99);
            if (roll < 5)
                send(ACT_INSERT, VAL_W'($urandom));
            else if (roll < 65)
                send(ACT_LOOKUP,
                     stored_values[$urandom_range(0, stored_values.size() - 1)]);
            else
                send(ACT_LOOKUP, VAL_W'($urandom));
        end
    endtask

    initial begin
        int fill_kind;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: lookups on a table that is not full, inserts at the value
        // extremes with duplicates and a shift all the way to entry 0, and
        // both clear codes.
        send(ACT_LOOKUP, 16'h0000);
        send(ACT_INSERT, 16'hFFFF);
        send(ACT_INSERT, 16'h0000);
        send(ACT_INSERT, 16'h8000);
        send(ACT_INSERT, 16'hFFFF);
        send(ACT_INSERT, 16'h0000);
        send(ACT_INSERT, 16'h7FFF);
        send(ACT_INSERT, 16'h0001);
        send(ACT_LOOKUP, 16'hFFFF);
        send(ACT_CLEAR_ALT, 16'h5555);
        send(ACT_INSERT, 16'hAAAA);
        send(ACT_INSERT, 16'h1234);
        send(ACT_CLEAR, 16'h0000);
        send(ACT_LOOKUP, 16'h1234);
        send(ACT_INSERT, 16'h0000);
        send(ACT_CLEAR, 16'hFFFF);

        // Broken sequence: a partial random fill abandoned by a clear.
        repeat (40)
            send(ACT_INSERT, VAL_W'($urandom));
        send(ACT_CLEAR_ALT, VAL_W'($urandom));
        wait_for_results();

        // One full fill of a randomly chosen kind with lookups on it; pause
        // for all results before the clear so the sender goes quiet.
        fill_kind = $urandom_range(0, 2);
        fill_table(fill_kind);
        probe_full_table();
        wait_for_results();
        send(ACT_CLEAR, VAL_W'($urandom));

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Hang guard, several times the slowest legal run.
    initial begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/smis_pkg.sv
rtl/core/smis_engine.sv
rtl/core/sorted_matrix_insert_and_search_unit.sv
tb/sv/sorted_table_checker.sv
tb/sv/sorted_matrix_insert_and_search_unit_tb.sv
